// File: design/etv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etv_pkg
// Shared widths, codes and the queue record of the edge to triangle block.
// ----------------------------------------------------------------------------
package etv_pkg;

  localparam int AddrBits     = 24;
  localparam int CoordBits    = 32;
  localparam int ColorBits    = 64;
  localparam int ThickBits    = 31;
  localparam int MagBits      = 33;
  localparam int NormBits     = 30;
  localparam int ScaleBits    = 30;
  localparam int LenBits      = 31;
  localparam int SumBits      = 62;
  localparam int ProdBits     = 60;
  localparam int QuotBits     = 31;
  localparam int MinSlot      = 24;
  localparam int VertexStride = 8;
  localparam int ThinSqLimit  = 43;
  localparam int Scale03      = 19661;
  localparam int InDataBits   = 368;
  localparam int OutDataBits  = 216;
  localparam int StatusBits   = 2;

  typedef enum logic [StatusBits-1:0] {
    StatusOk       = 2'd0,
    StatusSmall    = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  typedef struct packed {
    status_e                       status;
    logic [AddrBits-1:0]           offset;
    logic [2:0][CoordBits-1:0]     sp;
    logic [2:0][CoordBits-1:0]     ep;
    logic [ColorBits-1:0]          color;
    logic [CoordBits-1:0]          depth;
    logic [2:0]                    neg;
    logic [2:0][MagBits-1:0]       mag;
    logic                          long_edge;
    logic [ScaleBits-1:0]          scale;
  } edge_t;

endpackage

// File: design/edge_to_triangle_vertices.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_to_triangle_vertices
// Turns a graph edge into three triangle vertices, or one error beat.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields
// s_axis    in   tdata: edge record (368 bits)
// m_axis    out  tdata: vertex (216 bits), tuser: status, tlast: last of edge
// cfg       in   buffer_length (24 bits)
//
// In the back end a rejected edge is taken from the queue and then sends one
// error beat, and a short edge its three vertex beats, as the output takes them.
// For a long edge, normalization shifts one bit a cycle (up to 27 shifts),
// the square root runs over 32 steps, and the three offsets share one
// 31-step restoring divider.
// The front takes edges into a two-entry queue while the back end works;
// the output register is refilled in the cycle its beat is taken.
// Reset clears the buffer length to zero and empties the queue.
// ----------------------------------------------------------------------------
module edge_to_triangle_vertices (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [etv_pkg::AddrBits-1:0]    cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // slot_offset, slot_size, start_x/y/z, end_x/y/z, color_rgba, thickness, depth
  input  logic [etv_pkg::InDataBits-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // write_address, pos_x, pos_y, pos_z, vertex_color, vertex_depth
  output logic [etv_pkg::OutDataBits-1:0] m_axis_tdata,
  // status
  output logic [etv_pkg::StatusBits-1:0]  m_axis_tuser,
  output logic                            m_axis_tlast
);
  import etv_pkg::*;

  edge_t push_data;
  edge_t pop_data;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;

  etv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .queue_full_i (full),
    .push_o       (push),
    .edge_o       (push_data)
  );

  etv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  etv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != StatusOk |-> m_axis_tlast)
    else $error("error beat without last");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != StatusOk |-> m_axis_tdata == '0)
    else $error("error beat carries data");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

// File: design/etv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etv_front
// Holds the buffer length, checks the slot and classifies each edge.
// ----------------------------------------------------------------------------
module etv_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [etv_pkg::AddrBits-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [etv_pkg::InDataBits-1:0] in_data_i,
  input  logic                           queue_full_i,
  output logic                           push_o,
  output etv_pkg::edge_t                 edge_o
);
  import etv_pkg::*;

  logic [AddrBits-1:0]        buf_len_q;
  logic [AddrBits-1:0]        offset;
  logic [AddrBits-1:0]        size;
  logic [AddrBits:0]          slot_end;
  logic [2:0][CoordBits-1:0]  sp;
  logic [2:0][CoordBits-1:0]  ep;
  logic [2:0][MagBits:0]      d;
  logic [2:0][MagBits:0]      p;
  logic [2:0][MagBits-1:0]    mag;
  logic [2:0]                 neg;
  logic [ThickBits-1:0]       thick;
  logic [45:0]                scaled;
  logic [6:0]                 small_sq;
  logic                       big;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= '0;
    end else if (cfg_we_i) begin
      buf_len_q <= cfg_wdata_i;
    end
  end

  assign offset   = in_data_i[23:0];
  assign size     = in_data_i[47:24];
  assign sp[0]    = in_data_i[79:48];
  assign sp[1]    = in_data_i[111:80];
  assign sp[2]    = in_data_i[143:112];
  assign ep[0]    = in_data_i[175:144];
  assign ep[1]    = in_data_i[207:176];
  assign ep[2]    = in_data_i[239:208];
  assign thick    = in_data_i[334:304];
  assign slot_end = {1'b0, offset} + {1'b0, size};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = {{2{ep[i][CoordBits-1]}}, ep[i]} - {{2{sp[i][CoordBits-1]}}, sp[i]};
    end
    p[0] = -d[1];
    p[1] = d[0];
    p[2] = d[2];
    big      = 1'b0;
    small_sq = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = p[i][MagBits];
      mag[i] = neg[i] ? MagBits'(-p[i]) : p[i][MagBits-1:0];
      if (mag[i] >= MagBits'(7)) big = 1'b1;
      small_sq = small_sq + 7'(mag[i][2:0]) * 7'(mag[i][2:0]);
    end
  end

  // 0.3 * thickness, rounded half up
  assign scaled = 46'(thick) * 46'(Scale03) + 46'(32768);

  always_comb begin
    edge_o.offset    = offset;
    edge_o.sp        = sp;
    edge_o.ep        = ep;
    edge_o.color     = in_data_i[303:240];
    edge_o.depth     = in_data_i[366:335];
    edge_o.neg       = neg;
    edge_o.mag       = mag;
    edge_o.long_edge = big || (small_sq >= 7'(ThinSqLimit));
    edge_o.scale     = scaled[45:16];
    if (size < AddrBits'(MinSlot)) begin
      edge_o.status = StatusSmall;
    end else if (slot_end > {1'b0, buf_len_q}) begin
      edge_o.status = StatusOverflow;
    end else begin
      edge_o.status = StatusOk;
    end
  end

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

endmodule

// File: design/etv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etv_queue
// Two-entry queue of classified edges between front and back.
// ----------------------------------------------------------------------------
module etv_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  etv_pkg::edge_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output etv_pkg::edge_t pop_data_o,
  output logic           empty_o
);
  import etv_pkg::*;

  edge_t       mem_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign pop_data_o = mem_q[rd_ptr_q];
  assign full_o     = count_q == 2'd2;
  assign empty_o    = count_q == 2'd0;

endmodule

// File: design/etv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etv_back
// Computes the perpendicular offset and emits the vertex beats.
// ----------------------------------------------------------------------------
module etv_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  etv_pkg::edge_t                   pop_data_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [etv_pkg::OutDataBits-1:0]  out_data_o,
  output logic [etv_pkg::StatusBits-1:0]   out_user_o,
  output logic                             out_last_o
);
  import etv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_SQUARE, S_ACC, S_ROOT, S_MUL, S_DLOAD, S_DIV
  } state_e;

  // Beats are emitted while emit_q is set; the state register then rests in S_IDLE.
  state_e                     state_q;
  edge_t                      rec_q;
  logic [2:0][MagBits-1:0]    m_q;
  logic [1:0]                 idx_q;
  logic [1:0]                 v_q;
  logic                       emit_q;
  logic [ProdBits-1:0]        prod_q;
  logic [SumBits-1:0]         acc_q;
  logic [63:0]                res_q;
  logic [62:0]                bit_q;
  logic [LenBits-1:0]         len_q;
  logic [31:0]                rem_q;
  logic [QuotBits-1:0]        dq_q;
  logic [4:0]                 cnt_q;
  logic [2:0][QuotBits-1:0]   ofs_q;
  logic                       out_valid_q;
  logic [OutDataBits-1:0]     out_data_q;
  logic [StatusBits-1:0]      out_user_q;
  logic                       out_last_q;

  logic [MagBits-1:0]         mx;
  logic [NormBits-1:0]        mul_a;
  logic [NormBits-1:0]        mul_b;
  logic [63:0]                trial;
  logic [60:0]                num;
  logic [31:0]                rem2;
  logic                       ge;
  logic                       out_free;
  logic [2:0][CoordBits-1:0]  pos;
  logic [AddrBits-1:0]        waddr;

  function automatic logic [CoordBits-1:0] sat32(input logic [33:0] v);
    logic [CoordBits-1:0] r;
    if (!v[33] && v[32:31] != 2'b00) r = 32'h7FFF_FFFF;
    else if (v[33] && v[32:31] != 2'b11) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
  end

  assign mul_a = m_q[idx_q][NormBits-1:0];
  assign mul_b = (state_q == S_SQUARE) ? m_q[idx_q][NormBits-1:0] : rec_q.scale;
  assign trial = res_q + {1'b0, bit_q};
  assign num   = {1'b0, prod_q} + 61'(len_q >> 1);
  assign rem2  = {rem_q[30:0], dq_q[QuotBits-1]};
  assign ge    = rem2 >= {1'b0, len_q};
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o = (state_q == S_IDLE) && !emit_q && !empty_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (v_q == 2'd2) begin
        pos[i] = rec_q.ep[i];
      end else if ((v_q == 2'd0) ^ rec_q.neg[i]) begin
        pos[i] = sat32({{2{rec_q.sp[i][31]}}, rec_q.sp[i]} - {3'b000, ofs_q[i]});
      end else begin
        pos[i] = sat32({{2{rec_q.sp[i][31]}}, rec_q.sp[i]} + {3'b000, ofs_q[i]});
      end
    end
    waddr = rec_q.offset + AddrBits'({v_q, 3'b000});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rec_q       <= '0;
      m_q         <= '0;
      idx_q       <= '0;
      v_q         <= '0;
      emit_q      <= 1'b0;
      prod_q      <= '0;
      acc_q       <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      len_q       <= '0;
      rem_q       <= '0;
      dq_q        <= '0;
      cnt_q       <= '0;
      ofs_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !emit_q) out_valid_q <= 1'b0;
      if (emit_q) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
          if (rec_q.status != StatusOk) begin
            out_data_q <= '0;
            out_user_q <= rec_q.status;
            out_last_q <= 1'b1;
            emit_q     <= 1'b0;
          end else begin
            out_data_q <= {rec_q.depth, rec_q.color, pos[2], pos[1], pos[0], waddr};
            out_user_q <= StatusOk;
            out_last_q <= v_q == 2'd2;
            v_q        <= v_q + 2'd1;
            if (v_q == 2'd2) emit_q <= 1'b0;
          end
        end
      end else begin
        case (state_q)
          S_IDLE: begin
            if (!empty_i) begin
              rec_q <= pop_data_i;
              m_q   <= pop_data_i.mag;
              ofs_q <= '0;
              v_q   <= '0;
              idx_q <= '0;
              acc_q <= '0;
              if (pop_data_i.status != StatusOk || !pop_data_i.long_edge) begin
                emit_q <= 1'b1;
              end else begin
                state_q <= S_NORM;
              end
            end
          end
          S_NORM: begin
            // Bring the largest magnitude into [2^29, 2^30), one bit a cycle.
            if (mx[MagBits-1:30] != '0) begin
              for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
            end else if (!mx[29]) begin
              for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
            end else begin
              state_q <= S_SQUARE;
            end
          end
          S_SQUARE: begin
            prod_q  <= mul_a * mul_b;
            state_q <= S_ACC;
          end
          S_ACC: begin
            acc_q <= acc_q + SumBits'(prod_q);
            if (idx_q == 2'd2) begin
              idx_q   <= '0;
              res_q   <= '0;
              bit_q   <= {1'b1, 62'd0};
              state_q <= S_ROOT;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= S_SQUARE;
            end
          end
          S_ROOT: begin
            if ({2'b00, acc_q} >= trial) begin
              acc_q <= acc_q - trial[SumBits-1:0];
              res_q <= (res_q >> 1) + {1'b0, bit_q};
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
            if (bit_q == 63'd1) begin
              state_q <= S_MUL;
            end
          end
          S_MUL: begin
            len_q   <= res_q[LenBits-1:0];
            prod_q  <= mul_a * mul_b;
            state_q <= S_DLOAD;
          end
          S_DLOAD: begin
            rem_q   <= {2'b00, num[60:31]};
            dq_q    <= num[30:0];
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
          S_DIV: begin
            rem_q <= ge ? rem2 - {1'b0, len_q} : rem2;
            dq_q  <= {dq_q[QuotBits-2:0], ge};
            cnt_q <= cnt_q + 5'd1;
            if (cnt_q == 5'(QuotBits - 1)) begin
              ofs_q[idx_q] <= {dq_q[QuotBits-2:0], ge};
              if (idx_q == 2'd2) begin
                emit_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                idx_q   <= idx_q + 2'd1;
                state_q <= S_MUL;
              end
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

endmodule

// File: tb/edge_to_triangle_vertices_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_to_triangle_vertices_tb
// Sends edges with random gaps, predicts the vertex or error beats in
// fixed point and compares every output beat field by field.
// ----------------------------------------------------------------------------
module edge_to_triangle_vertices_tb;
  import etv_pkg::*;

  typedef struct packed {
    logic [23:0] wr_addr;
    logic [31:0] px, py, pz;
    logic [63:0] color;
    logic [31:0] depth;
    status_e     status;
    logic        last;
  } vtx_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [AddrBits-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataBits-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic [StatusBits-1:0] m_axis_tuser;
  logic m_axis_tlast;

  vtx_t vertex_q[$];
  logic [23:0] buf_len = '0;
  int errors = 0;
  int cycles = 0;
  int accept_stall = 1;

  edge_to_triangle_vertices dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("edge_to_triangle_vertices test failed");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("ERROR t=%0t %s", $time, what);
  endtask

  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Builds the expected beats of one edge.
  task automatic predict_vertices(input logic [23:0] ofs, siz,
                                  input logic [2:0][31:0] sp, ep,
                                  input logic [63:0] col, input logic [30:0] th,
                                  input logic [31:0] dep);
    vtx_t r;
    longint d[3], p[3], off[3], c;
    longint unsigned m[3], mx, s, len, q, sq;
    logic lng;
    r = '0;
    r.last = 1'b1;
    if (siz < MinSlot) begin
      r.status = StatusSmall;
      vertex_q.push_back(r);
      return;
    end
    if ({8'd0, ofs} + {8'd0, siz} > {8'd0, buf_len}) begin
      r.status = StatusOverflow;
      vertex_q.push_back(r);
      return;
    end
    for (int i = 0; i < 3; i++) d[i] = longint'($signed(ep[i])) - longint'($signed(sp[i]));
    p[0] = -d[1]; p[1] = d[0]; p[2] = d[2];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = p[i] < 0 ? -p[i] : p[i];
      if (m[i] > mx) mx = m[i];
      off[i] = 0;
    end
    if (mx >= (64'd1 << 30)) lng = 1;
    else begin
      sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      lng = sq >= ThinSqLimit;
    end
    if (lng) begin
      s = ({33'd0, th} * Scale03 + 32768) >> 16;
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * s + len / 2) / len;
        off[i] = p[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
    for (int v = 0; v < 3; v++) begin
      logic [31:0] pos[3];
      for (int i = 0; i < 3; i++) begin
        if (v == 0) c = longint'($signed(sp[i])) - off[i];
        else if (v == 1) c = longint'($signed(sp[i])) + off[i];
        else c = longint'($signed(ep[i]));
        pos[i] = sat(c);
      end
      r.wr_addr = ofs + 24'(VertexStride * v);
      r.px = pos[0]; r.py = pos[1]; r.pz = pos[2];
      r.color = col;
      r.depth = dep;
      r.status = StatusOk;
      r.last = (v == 2);
      vertex_q.push_back(r);
    end
  endtask

  // The beat stays valid after acceptance until the next edge or an idle period.
  task automatic send_edge(input logic [23:0] ofs, siz, input logic [2:0][31:0] sp, ep,
                           input logic [63:0] col, input logic [30:0] th,
                           input logic [31:0] dep, input bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    predict_vertices(ofs, siz, sp, ep, col, th, dep);
    s_axis_tdata <= {1'b0, dep, th, col, ep[2], ep[1], ep[0], sp[2], sp[1], sp[0], siz, ofs};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Output side: random stalls per beat, compare against the oldest expectation.
  initial begin
    vtx_t got, exp;
    int wait_n;
    forever begin
      wait_n = accept_stall ? $urandom_range(0, 16) : 0;
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n != 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      {got.depth, got.color, got.pz, got.py, got.px, got.wr_addr} = m_axis_tdata;
      got.status = status_e'(m_axis_tuser);
      got.last = m_axis_tlast;
      if (vertex_q.size() == 0) begin
        report("beat with nothing expected");
      end else begin
        exp = vertex_q.pop_front();
        if (got.wr_addr !== exp.wr_addr) report($sformatf("addr %h exp %h", got.wr_addr, exp.wr_addr));
        if (got.px !== exp.px) report($sformatf("pos_x %h exp %h", got.px, exp.px));
        if (got.py !== exp.py) report($sformatf("pos_y %h exp %h", got.py, exp.py));
        if (got.pz !== exp.pz) report($sformatf("pos_z %h exp %h", got.pz, exp.pz));
        if (got.color !== exp.color) report($sformatf("color %h exp %h", got.color, exp.color));
        if (got.depth !== exp.depth) report($sformatf("depth %h exp %h", got.depth, exp.depth));
        if (got.status !== exp.status) report($sformatf("status %0d exp %0d", got.status, exp.status));
        if (got.last !== exp.last) report($sformatf("last %b exp %b", got.last, exp.last));
      end
    end
  end

  task automatic drain_and_idle();
    s_axis_tvalid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_buffer_length(input logic [23:0] len);
    drain_and_idle();
    cfg_wdata_i <= len;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    buf_len = len;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 16) - 8;
      3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_edge(input int ok_pct);
    logic [2:0][31:0] sp, ep;
    logic [23:0] ofs, siz;
    for (int i = 0; i < 3; i++) begin
      sp[i] = rand_coord();
      ep[i] = ($urandom_range(0, 4) == 0) ? sp[i] + $urandom_range(0, 6) - 3 : rand_coord();
    end
    if ($urandom_range(0, 99) < ok_pct && buf_len >= 24) begin
      siz = 24'($urandom_range(24, buf_len > 4000 ? 4000 : buf_len));
      ofs = 24'($urandom_range(0, buf_len - siz));
    end else begin
      siz = ($urandom_range(0, 1)) ? 24'($urandom_range(0, 30)) : 24'($urandom);
      ofs = 24'($urandom);
    end
    send_edge(ofs, siz, sp, ep, {$urandom, $urandom}, 31'($urandom), $urandom);
  endtask

  task automatic test_slot_checks();
    logic [2:0][31:0] z;
    z = '0;
    send_edge(24'd0, 24'd0, z, z, '1, '1, '1);
    send_edge(24'd0, 24'd23, z, z, '1, '1, '1);
    send_edge(24'd0, 24'd24, z, z, '1, '1, '1);   // beyond zero-length buffer
    set_buffer_length(24'hffffff);
    send_edge(24'hffffff, 24'hffffff, z, z, '0, '0, '0);
    send_edge(24'hffffe7, 24'd24, z, z, '1, '0, 32'h80000000);
    send_edge(24'hffffe8, 24'd24, z, z, '1, '0, 32'h7fffffff);
    send_edge(24'd0, 24'hffffff, z, z, 64'h0123456789abcdef, '1, '0);
  endtask

  task automatic test_geometry();
    logic [2:0][31:0] a, b;
    a = '0; b = '0;
    b[0] = 32'd6; b[1] = 32'd3; b[2] = 32'd1;  // squared length 46, long
    send_edge(24'd100, 24'd24, a, b, '1, 31'h7fffffff, 32'd5);
    b[0] = 32'd6; b[1] = 32'd1; b[2] = 32'd1;  // squared length 38, short
    send_edge(24'd100, 24'd24, a, b, '1, 31'h7fffffff, 32'd5);
    a = {3{32'h7fffffff}}; b = {3{32'h80000000}};
    send_edge(24'd8, 24'd30, a, b, '0, 31'h7fffffff, '1);
    send_edge(24'd8, 24'd30, b, a, '1, 31'h7fffffff, '1);
    a = '0; b = '0; b[2] = 32'h00010000;
    send_edge(24'd0, 24'd24, a, b, '1, 31'h00010000, '0);
    b = '0; b[0] = 32'h00010000;
    send_edge(24'd0, 24'd24, a, b, '1, 31'h00010000, '0);
  endtask

  task automatic test_random(input int n);
    for (int k = 0; k < n; k++) begin
      if (k == n / 3) drain_and_idle();    // sender holds off until all results are back
      if (k == n / 2) accept_stall = 0;    // stretch of full-rate acceptance
      if (k == 3 * n / 4) accept_stall = 1;
      send_random_edge(80);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_slot_checks();
    test_geometry();
    test_random(150);
    set_buffer_length(24'd100);
    test_random(80);
    set_buffer_length(24'd0);
    test_random(20);
    set_buffer_length(24'h00a5a5);
    test_random(150);
    drain_and_idle();
    if (errors == 0) begin
      $display("edge_to_triangle_vertices test passed");
    end else begin
      $display("edge_to_triangle_vertices test failed");
    end
    $finish;
  end

endmodule

// File: edge_to_triangle_vertices.f
design/etv_pkg.sv
design/etv_front.sv
design/etv_queue.sv
design/etv_back.sv
design/edge_to_triangle_vertices.sv
tb/edge_to_triangle_vertices_tb.sv
